@@ src/kms_pkg.sv @@
// Package for the key matrix scanner: widths, constants and the job record
// passed from the sample front end to the event back end. No dependencies.
`default_nettype none

package kms_pkg;

  localparam int ROW_W    = 9;   // row lines per column
  localparam int COL_W    = 3;   // column number width
  localparam int ROWIDX_W = 4;   // row number width inside key_code
  localparam int CODE_W   = 7;   // key_code width

  localparam logic [ROW_W-1:0] ROW_MASK = 9'h1ff;
  localparam logic [ROW_W-1:0] TOP_ROW  = 9'h100;

  // One scan tick after classification
  typedef struct packed {
    logic [ROW_W-1:0] diff;   // changed rows
    logic [ROW_W-1:0] prev;   // held rows before this tick
    logic [COL_W-1:0] col;    // column sampled
    logic [COL_W-1:0] nextc;  // column driven after this tick
  } job_t;

endpackage

`default_nettype wire

@@ src/kms_front.sv @@
// Front end of the key matrix scanner: held-key map, column counter, change mask.
// Depends on kms_pkg.
`default_nettype none

module kms_front #(
  parameter int NUM_COLUMNS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [8:0]        row_sample,
  output kms_pkg::job_t          job
);
  import kms_pkg::*;

  localparam int CIDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

  logic [ROW_W-1:0] held_r [NUM_COLUMNS];
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] sample;
  logic [ROW_W-1:0] prev;

  assign sample  = row_sample & ROW_MASK;
  assign prev    = held_r[col_r[CIDX_W-1:0]];
  assign col_nxt = (col_r == LAST_COL) ? '0 : col_r + COL_W'(1);

  always_comb begin
    job.diff  = (prev ^ sample) & ROW_MASK;
    job.prev  = prev;
    job.col   = col_r;
    job.nextc = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        held_r[i] <= '0;
      end
    end else if (accept) begin
      held_r[col_r[CIDX_W-1:0]] <= sample;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/kms_fifo.sv @@
// Two-entry job queue between the scanner front end and back end.
// Depends on kms_pkg.
`default_nettype none

module kms_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  kms_pkg::job_t       push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output kms_pkg::job_t       head_job
);
  import kms_pkg::*;

  job_t        mem_r [2];
  logic        wptr_r;
  logic        rptr_r;
  logic [1:0]  cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/kms_back.sv @@
// Back end of the key matrix scanner: walks the change mask from row 0 down, one
// event beat per cycle unless out_ready stalls, into a registered output. Depends on kms_pkg.
`default_nettype none

module kms_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      job_valid,
  input  kms_pkg::job_t                  job_in,
  output logic                           job_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_event_valid,
  output logic [kms_pkg::CODE_W-1:0]     out_key_code,
  output logic                           out_released,
  output logic [kms_pkg::COL_W-1:0]      out_next_column,
  output logic                           out_last
);
  import kms_pkg::*;

  job_t                cur_r, cur_nxt;
  logic                busy_r, busy_nxt;
  logic                valid_r;
  logic                ev_r, rel_r, last_r;
  logic [CODE_W-1:0]   code_r;
  logic [COL_W-1:0]    nc_r;

  logic                advance;
  logic                src_ok;
  job_t                src;
  logic                found;
  logic [ROWIDX_W-1:0] r_idx;
  logic [ROW_W-1:0]    sel;
  logic [ROW_W-1:0]    rem;

  assign advance = !valid_r || out_ready;
  assign src_ok  = busy_r || job_valid;
  assign src     = busy_r ? cur_r : job_in;
  assign job_pop = advance && !busy_r && job_valid;

  // Pick the highest changed bit, which is the lowest row number
  always_comb begin
    found = 1'b0;
    r_idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (!found && src.diff[ROW_W-1-i]) begin
        found = 1'b1;
        r_idx = ROWIDX_W'(i);
      end
    end
  end

  assign sel = found ? (TOP_ROW >> r_idx) : '0;
  assign rem = src.diff & ~sel;

  always_comb begin
    cur_nxt      = src;
    cur_nxt.diff = rem;
    busy_nxt     = busy_r;
    if (advance) begin
      busy_nxt = src_ok && (rem != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (advance) begin
        valid_r <= src_ok;
      end
    end
  end

  // Payload: load on every advancing cycle that has a source
  always_ff @(posedge clk) begin
    if (advance && src_ok) begin
      cur_r  <= cur_nxt;
      ev_r   <= found;
      code_r <= found ? {src.col, r_idx} : '0;
      rel_r  <= |(src.prev & sel);
      nc_r   <= src.nextc;
      last_r <= (rem == '0);
    end
  end

  assign out_valid       = valid_r;
  assign out_event_valid = ev_r;
  assign out_key_code    = code_r;
  assign out_released    = rel_r;
  assign out_next_column = nc_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

@@ src/key_matrix_scanner_top.sv @@
// Key matrix scanner top: one result beat per cycle while out_tready is high;
// the first result of a tick passes through the job queue and the back end's
// output register. A tick with k changed rows yields max(k,1) result beats
// (1..9); a two-entry job queue lets ticks be taken while earlier ticks drain.
// Synchronous active-low reset clears the held-key map, column and job queue.
`default_nettype none

module key_matrix_scanner_top #(
  parameter int NUM_COLUMNS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [8:0] row_sample, [15:9] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [6:0] key_code, [7] released,
                                       // [10:8] next_column, [15:11] zero
  output logic             out_tuser,  // [0] event_valid
  output logic             out_tlast
);
  import kms_pkg::*;

  logic              accept;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  job_t              f_job;
  job_t              q_job;
  logic [CODE_W-1:0] key_code;
  logic              released;
  logic [COL_W-1:0]  next_column;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  kms_front #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .row_sample (in_tdata[8:0]),
    .job        (f_job)
  );

  kms_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_job   (f_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  kms_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_valid),
    .job_in          (q_job),
    .job_pop         (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_event_valid (out_tuser),
    .out_key_code    (key_code),
    .out_released    (released),
    .out_next_column (next_column),
    .out_last        (out_tlast)
  );

  assign out_tdata = {5'b0, next_column, released, key_code};

endmodule

`default_nettype wire
